// ----- src/ptc_pkg.sv -----
// Shared types and constants for the pressure and temperature compensation block.
`timescale 1ns / 1ps

package ptc_pkg;

    localparam int FRONT_STAGES = 13;
    localparam int DIV_STEPS    = 64;
    localparam int BACK_STAGES  = 7;
    localparam int TEMP_HOLD    = 8;
    localparam int PC_HOLD      = 9;

    localparam logic signed [22:0] TF_OFFSET = 23'sd128000;
    localparam logic [20:0]        P_BASE    = 21'd1048576;
    localparam logic [11:0]        K3125     = 12'd3125;
    localparam logic signed [24:0] T_ROUND   = 25'sd128;
    localparam logic [63:0]        P1_BIAS   = 64'h0000_8000_0000_0000;

    typedef enum logic [1:0] {
        CFG_TEMP_CALIB  = 2'd0,
        CFG_PRESS_LOW   = 2'd1,
        CFG_PRESS_HIGH  = 2'd2,
        CFG_PRESS_P9    = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [15:0] p1;
        logic signed [15:0] p2;
        logic signed [15:0] p3;
        logic signed [15:0] p4;
        logic signed [15:0] p5;
        logic signed [15:0] p6;
        logic signed [15:0] p7;
        logic signed [15:0] p8;
        logic signed [15:0] p9;
    } calib_t;

    typedef struct packed {
        logic [30:0]        dmag;
        logic               neg;
        logic               ok;
        logic signed [31:0] temp;
    } div_side_t;

    typedef struct packed {
        logic [63:0] nmag;
        div_side_t   side;
    } div_in_t;

    typedef struct packed {
        logic [63:0] quo;
        div_side_t   side;
    } div_out_t;

    typedef struct packed {
        logic signed [31:0] temperature_centi;
        logic [31:0]        pressure_q24_8;
        logic               pressure_valid;
    } res_t;

endpackage

// ----- src/ptc_if.sv -----
// Stream channel interfaces for raw samples and compensated results.
`timescale 1ns / 1ps

interface ptc_in_if;
    logic        valid;
    logic        ready;
    logic [19:0] raw_pressure;
    logic [19:0] raw_temperature;

    modport source (output valid, output raw_pressure, output raw_temperature, input ready);
    modport sink (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

interface ptc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] temperature_centi;
    logic [31:0]        pressure_q24_8;
    logic               pressure_valid;

    modport source (output valid, output temperature_centi, output pressure_q24_8,
                    output pressure_valid, input ready);
    modport sink (input valid, input temperature_centi, input pressure_q24_8,
                  input pressure_valid, output ready);
endinterface

// ----- src/pressure_temperature_compensation.sv -----
// Top level of the pressure and temperature compensation pipeline.
// The depth is set by the 64-stage quotient pipeline between front and back.
// Throughput: one beat per cycle while the skid register is empty.
// A skid register lets one more beat in while a result waits at the output.
// Reset clears all valid bits and sets every calibration register to zero.
`timescale 1ns / 1ps

module pressure_temperature_compensation (
    input  logic              clk,
    input  logic              rst_n,
    ptc_in_if.sink            in_ch,
    ptc_out_if.source         out_ch,
    input  logic              cfg_we,
    input  ptc_pkg::cfg_idx_t cfg_index,
    input  logic [63:0]       cfg_data
);
    import ptc_pkg::*;

    logic [47:0] temp_calib_reg;
    logic [63:0] press_low_reg;
    logic [63:0] press_high_reg;
    logic [15:0] press_p9_reg;
    calib_t      calib;

    logic        en;
    logic        front_valid, div_valid, pipe_valid, pipe_take;
    div_in_t     front_data;
    div_out_t    div_data;
    res_t        pipe_data;

    logic        out_valid_reg, skid_valid_reg;
    res_t        out_data_reg, skid_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_calib_reg <= '0;
            press_low_reg  <= '0;
            press_high_reg <= '0;
            press_p9_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TEMP_CALIB: temp_calib_reg <= cfg_data[47:0];
                CFG_PRESS_LOW:  press_low_reg  <= cfg_data;
                CFG_PRESS_HIGH: press_high_reg <= cfg_data;
                CFG_PRESS_P9:   press_p9_reg   <= cfg_data[15:0];
            endcase
        end
    end

    always_comb
    begin
        calib.t1 = temp_calib_reg[15:0];
        calib.t2 = temp_calib_reg[31:16];
        calib.t3 = temp_calib_reg[47:32];
        calib.p1 = press_low_reg[15:0];
        calib.p2 = press_low_reg[31:16];
        calib.p3 = press_low_reg[47:32];
        calib.p4 = press_low_reg[63:48];
        calib.p5 = press_high_reg[15:0];
        calib.p6 = press_high_reg[31:16];
        calib.p7 = press_high_reg[47:32];
        calib.p8 = press_high_reg[63:48];
        calib.p9 = press_p9_reg;
    end

    assign en          = !skid_valid_reg;
    assign in_ch.ready = en;
    assign pipe_take   = en && pipe_valid;

    ptc_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (en),
        .in_valid        (in_ch.valid),
        .raw_pressure    (in_ch.raw_pressure),
        .raw_temperature (in_ch.raw_temperature),
        .calib           (calib),
        .out_valid       (front_valid),
        .out_data        (front_data)
    );

    ptc_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .in_data   (front_data),
        .out_valid (div_valid),
        .out_data  (div_data)
    );

    ptc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_valid),
        .in_data   (div_data),
        .calib     (calib),
        .out_valid (pipe_valid),
        .out_data  (pipe_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ch.ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= pipe_take;
            end
        end
        else if (pipe_take)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ch.ready)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : pipe_data;
        end
        else if (pipe_take)
        begin
            skid_data_reg <= pipe_data;
        end
    end

    assign out_ch.valid             = out_valid_reg;
    assign out_ch.temperature_centi = out_data_reg.temperature_centi;
    assign out_ch.pressure_q24_8    = out_data_reg.pressure_q24_8;
    assign out_ch.pressure_valid    = out_data_reg.pressure_valid;

`ifndef SYNTH
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid beat held without an output beat");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !out_ch.ready && pipe_valid))
        else $error("skid filled while output was free");

    a_pipe_hold: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && pipe_valid |=> pipe_valid && $stable(pipe_data))
        else $error("pipeline moved while stalled");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.pressure_valid |-> out_ch.pressure_q24_8 == 32'd0)
        else $error("invalid pressure not zero");
`endif

endmodule

// ----- src/ptc_front.sv -----
// Temperature path and pressure numerator and divisor pipeline.
`timescale 1ns / 1ps

module ptc_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [19:0]       raw_pressure,
    input  logic [19:0]       raw_temperature,
    input  ptc_pkg::calib_t   calib,
    output logic              out_valid,
    output ptc_pkg::div_in_t  out_data
);
    import ptc_pkg::*;

    logic [FRONT_STAGES-1:0] vld_reg;

    logic signed [17:0] s1_a_reg, s1_a_next;
    logic signed [16:0] s1_b_reg, s1_b_next;
    logic [20:0]        pc_reg [PC_HOLD];
    logic [20:0]        pc_next;

    logic signed [33:0] at_prod, bb_prod;
    logic signed [20:0] s2_v1_reg, s2_v1_next;
    logic signed [19:0] s2_sq_reg, s2_sq_next;

    logic signed [35:0] sqt_prod;
    logic signed [20:0] s3_v1_reg;
    logic signed [17:0] s3_v2_reg, s3_v2_next;

    logic signed [21:0] s4_tf_reg, s4_tf_next;

    logic signed [24:0] tf25, t5;
    logic signed [22:0] tf23;
    logic signed [31:0] temp_reg [TEMP_HOLD];
    logic signed [31:0] temp_next;
    logic signed [22:0] s5_d_reg, s5_d_next;

    logic signed [45:0] dd_prod;
    logic [43:0]        s6_dd_reg, s6_dd_next;
    logic signed [38:0] s6_dp5_reg, s6_dp5_next, s6_dp2_reg, s6_dp2_next;

    logic signed [38:0] s7_q6l_reg, s7_q6l_next, s7_q6h_reg, s7_q6h_next;
    logic signed [38:0] s7_q3l_reg, s7_q3l_next, s7_q3h_reg, s7_q3h_next;
    logic signed [38:0] s7_dp5_reg, s7_dp2_reg;

    logic [63:0]        s8_q6_reg, s8_q6_next, s8_q3_reg, s8_q3_next;
    logic signed [38:0] s8_dp5_reg, s8_dp2_reg;

    logic [63:0]        s9_v2_reg, s9_v2_next, s9_v1a_reg, s9_v1a_next;

    logic [63:0]        s10_s_reg, s10_s_next, s10_diff_reg, s10_diff_next;

    logic [47:0]        s11_pl_reg, s11_pl_next;
    logic [31:0]        s11_ph_reg, s11_ph_next;
    logic [43:0]        s11_nl_reg, s11_nl_next;
    logic [31:0]        s11_nh_reg, s11_nh_next;

    logic [63:0]        v1p;
    logic [30:0]        s12_dv_reg, s12_dv_next;
    logic [63:0]        s12_num_reg, s12_num_next;

    div_in_t            s13_reg, s13_next;

    always_comb
    begin
        s1_a_next = $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, calib.t1, 1'b0});
        s1_b_next = $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, calib.t1});
        pc_next   = P_BASE - {1'b0, raw_pressure};

        at_prod    = s1_a_reg * calib.t2;
        bb_prod    = s1_b_reg * s1_b_reg;
        s2_v1_next = at_prod[31:11];
        s2_sq_next = bb_prod[31:12];

        sqt_prod   = s2_sq_reg * calib.t3;
        s3_v2_next = sqt_prod[31:14];

        s4_tf_next = s3_v1_reg + s3_v2_reg;

        tf25      = s4_tf_reg;
        tf23      = s4_tf_reg;
        t5        = (tf25 <<< 2) + tf25 + T_ROUND;
        temp_next = $signed(t5[24:8]);
        s5_d_next = tf23 - TF_OFFSET;

        dd_prod     = s5_d_reg * s5_d_reg;
        s6_dd_next  = dd_prod[43:0];
        s6_dp5_next = s5_d_reg * calib.p5;
        s6_dp2_next = s5_d_reg * calib.p2;

        s7_q6l_next = $signed({1'b0, s6_dd_reg[21:0]}) * calib.p6;
        s7_q6h_next = $signed({1'b0, s6_dd_reg[43:22]}) * calib.p6;
        s7_q3l_next = $signed({1'b0, s6_dd_reg[21:0]}) * calib.p3;
        s7_q3h_next = $signed({1'b0, s6_dd_reg[43:22]}) * calib.p3;

        s8_q6_next = {{3{s7_q6h_reg[38]}}, s7_q6h_reg, 22'd0}
                   + {{25{s7_q6l_reg[38]}}, s7_q6l_reg};
        s8_q3_next = {{3{s7_q3h_reg[38]}}, s7_q3h_reg, 22'd0}
                   + {{25{s7_q3l_reg[38]}}, s7_q3l_reg};

        s9_v2_next  = s8_q6_reg
                    + {{8{s8_dp5_reg[38]}}, s8_dp5_reg, 17'd0}
                    + {{13{calib.p4[15]}}, calib.p4, 35'd0};
        s9_v1a_next = {{8{s8_q3_reg[63]}}, s8_q3_reg[63:8]}
                    + {{13{s8_dp2_reg[38]}}, s8_dp2_reg, 12'd0};

        s10_s_next    = s9_v1a_reg + P1_BIAS;
        s10_diff_next = {12'd0, pc_reg[PC_HOLD-1], 31'd0} - s9_v2_reg;

        s11_pl_next = s10_s_reg[31:0] * calib.p1;
        s11_ph_next = s10_s_reg[63:32] * {16'd0, calib.p1};
        s11_nl_next = s10_diff_reg[31:0] * K3125;
        s11_nh_next = s10_diff_reg[63:32] * {20'd0, K3125};

        v1p          = {16'd0, s11_pl_reg} + {s11_ph_reg, 32'd0};
        s12_dv_next  = v1p[63:33];
        s12_num_next = {20'd0, s11_nl_reg} + {s11_nh_reg, 32'd0};

        s13_next.nmag      = s12_num_reg[63] ? (64'd0 - s12_num_reg) : s12_num_reg;
        s13_next.side.dmag = s12_dv_reg[30] ? (31'd0 - s12_dv_reg) : s12_dv_reg;
        s13_next.side.neg  = s12_num_reg[63] ^ s12_dv_reg[30];
        s13_next.side.ok   = (s12_dv_reg != 31'd0);
        s13_next.side.temp = temp_reg[TEMP_HOLD-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[FRONT_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_a_reg   <= s1_a_next;
            s1_b_reg   <= s1_b_next;
            pc_reg[0]  <= pc_next;
            for (int i = 1; i < PC_HOLD; i++)
            begin
                pc_reg[i] <= pc_reg[i-1];
            end
            s2_v1_reg  <= s2_v1_next;
            s2_sq_reg  <= s2_sq_next;
            s3_v1_reg  <= s2_v1_reg;
            s3_v2_reg  <= s3_v2_next;
            s4_tf_reg  <= s4_tf_next;
            temp_reg[0] <= temp_next;
            for (int i = 1; i < TEMP_HOLD; i++)
            begin
                temp_reg[i] <= temp_reg[i-1];
            end
            s5_d_reg    <= s5_d_next;
            s6_dd_reg   <= s6_dd_next;
            s6_dp5_reg  <= s6_dp5_next;
            s6_dp2_reg  <= s6_dp2_next;
            s7_q6l_reg  <= s7_q6l_next;
            s7_q6h_reg  <= s7_q6h_next;
            s7_q3l_reg  <= s7_q3l_next;
            s7_q3h_reg  <= s7_q3h_next;
            s7_dp5_reg  <= s6_dp5_reg;
            s7_dp2_reg  <= s6_dp2_reg;
            s8_q6_reg   <= s8_q6_next;
            s8_q3_reg   <= s8_q3_next;
            s8_dp5_reg  <= s7_dp5_reg;
            s8_dp2_reg  <= s7_dp2_reg;
            s9_v2_reg   <= s9_v2_next;
            s9_v1a_reg  <= s9_v1a_next;
            s10_s_reg   <= s10_s_next;
            s10_diff_reg <= s10_diff_next;
            s11_pl_reg  <= s11_pl_next;
            s11_ph_reg  <= s11_ph_next;
            s11_nl_reg  <= s11_nl_next;
            s11_nh_reg  <= s11_nh_next;
            s12_dv_reg  <= s12_dv_next;
            s12_num_reg <= s12_num_next;
            s13_reg     <= s13_next;
        end
    end

    assign out_valid = vld_reg[FRONT_STAGES-1];
    assign out_data  = s13_reg;

endmodule

// ----- src/ptc_div.sv -----
// Restoring divider, one quotient bit per pipeline stage.
`timescale 1ns / 1ps

module ptc_div (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  ptc_pkg::div_in_t  in_data,
    output logic              out_valid,
    output ptc_pkg::div_out_t out_data
);
    import ptc_pkg::*;

    logic [DIV_STEPS-1:0] vld_reg;
    logic [30:0]          rem_reg  [DIV_STEPS];
    logic [63:0]          word_reg [DIV_STEPS];
    div_side_t            side_reg [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        logic [30:0] rem_in;
        logic [63:0] word_in;
        div_side_t   side_in;
        logic [31:0] trial;
        logic [31:0] diff;
        logic        ge;
        logic [30:0] rem_next;
        logic [63:0] word_next;

        if (k == 0)
        begin : g_first
            assign rem_in  = '0;
            assign word_in = in_data.nmag;
            assign side_in = in_data.side;
        end
        else
        begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign word_in = word_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        always_comb
        begin
            trial     = {rem_in, word_in[63]};
            diff      = trial - {1'b0, side_in.dmag};
            ge        = (trial >= {1'b0, side_in.dmag});
            rem_next  = ge ? diff[30:0] : trial[30:0];
            word_next = {word_in[62:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                word_reg[k] <= word_next;
                side_reg[k] <= side_in;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DIV_STEPS-2:0], in_valid};
        end
    end

    assign out_valid     = vld_reg[DIV_STEPS-1];
    assign out_data.quo  = word_reg[DIV_STEPS-1];
    assign out_data.side = side_reg[DIV_STEPS-1];

endmodule

// ----- src/ptc_back.sv -----
// Post-division pressure correction and output saturation pipeline.
`timescale 1ns / 1ps

module ptc_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  ptc_pkg::div_out_t in_data,
    input  ptc_pkg::calib_t   calib,
    output logic              out_valid,
    output ptc_pkg::res_t     out_data
);
    import ptc_pkg::*;

    logic [BACK_STAGES-1:0] vld_reg;

    logic [63:0]        b1_p_reg, b1_p_next;
    logic               ok_reg [BACK_STAGES-1];
    logic signed [31:0] temp_reg [BACK_STAGES-1];

    logic [63:0]        ps;
    logic [63:0]        b2_m0_reg, b2_m0_next;
    logic [31:0]        b2_m1_reg, b2_m1_next;
    logic signed [48:0] b2_r0_reg, b2_r0_next;
    logic [31:0]        b2_r1_reg, b2_r1_next;
    logic [63:0]        b2_p_reg;

    logic [63:0]        bp;
    logic [63:0]        b3_x_reg, b3_x_next, b3_b_reg, b3_b_next, b3_p_reg;

    logic signed [48:0] b4_x0_reg, b4_x0_next;
    logic [31:0]        b4_x1_reg, b4_x1_next;
    logic [63:0]        b4_b_reg, b4_p_reg;

    logic [63:0]        ap;
    logic [63:0]        b5_a_reg, b5_a_next, b5_b_reg, b5_p_reg;

    logic [63:0]        b6_sum_reg, b6_sum_next;

    logic [63:0]        r;
    res_t               b7_reg, b7_next;

    always_comb
    begin
        b1_p_next = in_data.side.neg ? (64'd0 - in_data.quo) : in_data.quo;

        ps         = {{13{b1_p_reg[63]}}, b1_p_reg[63:13]};
        b2_m0_next = ps[31:0] * ps[31:0];
        b2_m1_next = ps[31:0] * ps[63:32];
        b2_r0_next = $signed({1'b0, b1_p_reg[31:0]}) * calib.p8;
        b2_r1_next = b1_p_reg[63:32] * {{16{calib.p8[15]}}, calib.p8};

        b3_x_next = b2_m0_reg + {b2_m1_reg[30:0], 33'd0};
        bp        = {{15{b2_r0_reg[48]}}, b2_r0_reg} + {b2_r1_reg, 32'd0};
        b3_b_next = {{19{bp[63]}}, bp[63:19]};

        b4_x0_next = $signed({1'b0, b3_x_reg[31:0]}) * calib.p9;
        b4_x1_next = b3_x_reg[63:32] * {{16{calib.p9[15]}}, calib.p9};

        ap        = {{15{b4_x0_reg[48]}}, b4_x0_reg} + {b4_x1_reg, 32'd0};
        b5_a_next = {{25{ap[63]}}, ap[63:25]};

        b6_sum_next = b5_p_reg + b5_a_reg + b5_b_reg;

        r = {{8{b6_sum_reg[63]}}, b6_sum_reg[63:8]} + {{44{calib.p7[15]}}, calib.p7, 4'd0};
        b7_next.temperature_centi = temp_reg[BACK_STAGES-2];
        b7_next.pressure_valid    = ok_reg[BACK_STAGES-2];
        priority if (!ok_reg[BACK_STAGES-2] || r[63])
        begin
            b7_next.pressure_q24_8 = 32'd0;
        end
        else if (r[63:32] != 32'd0)
        begin
            b7_next.pressure_q24_8 = 32'hFFFF_FFFF;
        end
        else
        begin
            b7_next.pressure_q24_8 = r[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[BACK_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_p_reg    <= b1_p_next;
            ok_reg[0]   <= in_data.side.ok;
            temp_reg[0] <= in_data.side.temp;
            for (int i = 1; i < BACK_STAGES - 1; i++)
            begin
                ok_reg[i]   <= ok_reg[i-1];
                temp_reg[i] <= temp_reg[i-1];
            end
            b2_m0_reg  <= b2_m0_next;
            b2_m1_reg  <= b2_m1_next;
            b2_r0_reg  <= b2_r0_next;
            b2_r1_reg  <= b2_r1_next;
            b2_p_reg   <= b1_p_reg;
            b3_x_reg   <= b3_x_next;
            b3_b_reg   <= b3_b_next;
            b3_p_reg   <= b2_p_reg;
            b4_x0_reg  <= b4_x0_next;
            b4_x1_reg  <= b4_x1_next;
            b4_b_reg   <= b3_b_reg;
            b4_p_reg   <= b3_p_reg;
            b5_a_reg   <= b5_a_next;
            b5_b_reg   <= b4_b_reg;
            b5_p_reg   <= b4_p_reg;
            b6_sum_reg <= b6_sum_next;
            b7_reg     <= b7_next;
        end
    end

    assign out_valid = vld_reg[BACK_STAGES-1];
    assign out_data  = b7_reg;

endmodule
